[src/pdle_pkg.sv]
package pdle_pkg;

	localparam int QueueDepth = 32;
	localparam int HandleBits = 8;
	localparam int IdxBits = $clog2(QueueDepth);
	localparam int CntBits = $clog2(QueueDepth + 1);

	localparam logic [2:0] KIND_QUEUED   = 3'd0;
	localparam logic [2:0] KIND_DROPPED  = 3'd1;
	localparam logic [2:0] KIND_FULL     = 3'd2;
	localparam logic [2:0] KIND_TICK     = 3'd3;
	localparam logic [2:0] KIND_RELEASED = 3'd4;

	localparam logic [1:0] CFG_LOSS = 2'd0;
	localparam logic [1:0] CFG_MIN  = 2'd1;
	localparam logic [1:0] CFG_SPAN = 2'd2;

	typedef struct packed {
		logic        command;
		logic [7:0]  packet_handle;
		logic [15:0] rand_loss;
		logic [15:0] rand_delay;
	} cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] released_handle;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [31:0]           when;
		logic [15:0]           seq;
		logic [HandleBits-1:0] handle;
	} slot_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CALC, ST_EXEC, ST_UP_RD, ST_UP_CMP, ST_ROOT_RD, ST_ROOT_CHK,
		ST_POP_RD, ST_POP_LD, ST_DN_L, ST_DN_R, ST_DN_CMP
	} state_t;

	// Entry a goes before entry b: earlier release relative to now, then older.
	function automatic logic goes_first(slot_t a, slot_t b, logic [31:0] now);
		logic [31:0] da;
		logic [31:0] db;
		logic [15:0] ds;
		da = a.when - now;
		db = b.when - now;
		ds = a.seq - b.seq;
		if (da != db) return $signed(da) < $signed(db);
		return ds[15];
	endfunction

endpackage

[src/pdle_ram.sv]
module pdle_ram (
	input  logic                          clk,
	input  logic                          we,
	input  logic [pdle_pkg::IdxBits-1:0]  waddr,
	input  pdle_pkg::slot_t               wdata,
	input  logic [pdle_pkg::IdxBits-1:0]  raddr,
	output pdle_pkg::slot_t               rdata
);

	pdle_pkg::slot_t mem [pdle_pkg::QueueDepth];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

[src/packet_delay_loss_emulator.sv]
// Link impairment block with a binary min-heap of pending packets in one RAM.
// An item is taken when start is high and busy is low. The first beat of an
// item, its status, comes in ROOT_CHK after CALC, EXEC and ROOT_RD for a tick
// or a refused packet; a queued packet first climbs the heap in UP_RD and
// UP_CMP. Each released packet then adds a pass through POP_RD, POP_LD and
// the DN states, since the pop sinks the last entry through the heap, one
// child read at a time. Every beat is held back until it is known whether
// another beat follows, so that last can be set. busy drops after the final
// beat, and the next item can be taken as soon as busy is low.
// Results appear for one cycle with result_valid and cannot be stalled.
module packet_delay_loss_emulator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  pdle_pkg::cmd_t    cmd,
	output logic              result_valid,
	output pdle_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [16:0]       cfg_data
);

	localparam int IB = pdle_pkg::IdxBits;
	localparam int CB = pdle_pkg::CntBits;

	pdle_pkg::state_t state_q, state_d;
	logic [16:0] loss_q;
	logic [15:0] min_q, span_q;
	logic [CB-1:0] count_q;
	logic [31:0] now_q;
	logic [15:0] arr_q;
	pdle_pkg::cmd_t cmd_q;
	logic [31:0] prod_q;
	logic [IB-1:0] idx_q, best_idx_q;
	pdle_pkg::slot_t cur_q, best_q;
	logic [2:0] pend_kind_q;
	logic [7:0] pend_handle_q;

	logic we;
	logic [IB-1:0] waddr, raddr;
	pdle_pkg::slot_t wdata, rdata;

	logic [2:0] status_kind;
	logic [31:0] new_when;
	pdle_pkg::slot_t new_slot;
	logic [IB-1:0] parent;
	logic [IB:0] lidx, ridx;
	logic [31:0] root_diff;
	logic root_due;
	logic left_first, right_first;

	pdle_ram u_ram (.clk, .we, .waddr, .wdata, .raddr, .rdata);

	assign cfg_ready = 1'b1;
	assign busy = (state_q != pdle_pkg::ST_IDLE);

	// Heap arithmetic on the current index.
	assign parent = (idx_q - IB'(1)) >> 1;
	assign lidx = {idx_q, 1'b1};
	assign ridx = {idx_q, 1'b0} + (IB+1)'(2);

	// New entry for a queued packet.
	assign new_when = now_q + {16'd0, min_q} + {16'd0, prod_q[31:16]};
	assign new_slot = {new_when, arr_q, cmd_q.packet_handle[pdle_pkg::HandleBits-1:0]};

	// Root entry is due when its release time is not later than now.
	assign root_diff = rdata.when - now_q;
	assign root_due = (count_q != '0) && (root_diff[31] || (root_diff == '0));

	assign left_first = pdle_pkg::goes_first(rdata, cur_q, now_q);
	assign right_first = pdle_pkg::goes_first(rdata, best_q, now_q);

	// Status of the item at hand.
	always_comb begin
		if (cmd_q.command) status_kind = pdle_pkg::KIND_TICK;
		else if ({1'b0, cmd_q.rand_loss} < loss_q) status_kind = pdle_pkg::KIND_DROPPED;
		else if (count_q == CB'(pdle_pkg::QueueDepth)) status_kind = pdle_pkg::KIND_FULL;
		else status_kind = pdle_pkg::KIND_QUEUED;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_q <= '0;
			min_q  <= '0;
			span_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pdle_pkg::CFG_LOSS: loss_q <= cfg_data;
				pdle_pkg::CFG_MIN:  min_q  <= cfg_data[15:0];
				pdle_pkg::CFG_SPAN: span_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Next state, memory port and result beat.
	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = idx_q;
		wdata = cur_q;
		raddr = idx_q;
		result_valid = 1'b0;
		result = '0;
		unique case (state_q)
			pdle_pkg::ST_IDLE: if (start) state_d = pdle_pkg::ST_CALC;
			pdle_pkg::ST_CALC: state_d = pdle_pkg::ST_EXEC;
			pdle_pkg::ST_EXEC: begin
				state_d = (status_kind == pdle_pkg::KIND_QUEUED) ? pdle_pkg::ST_UP_RD
					: pdle_pkg::ST_ROOT_RD;
			end
			pdle_pkg::ST_UP_RD: begin
				if (idx_q == '0) begin
					we = 1'b1;
					state_d = pdle_pkg::ST_ROOT_RD;
				end else begin
					raddr = parent;
					state_d = pdle_pkg::ST_UP_CMP;
				end
			end
			pdle_pkg::ST_UP_CMP: begin
				we = 1'b1;
				if (pdle_pkg::goes_first(cur_q, rdata, now_q)) begin
					wdata = rdata;
					state_d = pdle_pkg::ST_UP_RD;
				end else begin
					state_d = pdle_pkg::ST_ROOT_RD;
				end
			end
			pdle_pkg::ST_ROOT_RD: begin
				raddr = '0;
				state_d = pdle_pkg::ST_ROOT_CHK;
			end
			pdle_pkg::ST_ROOT_CHK: begin
				result_valid = 1'b1;
				result.kind = pend_kind_q;
				result.released_handle = pend_handle_q;
				result.last = !root_due;
				state_d = root_due ? pdle_pkg::ST_POP_RD : pdle_pkg::ST_IDLE;
			end
			pdle_pkg::ST_POP_RD: begin
				raddr = count_q[IB-1:0];
				state_d = (count_q == '0) ? pdle_pkg::ST_ROOT_RD : pdle_pkg::ST_POP_LD;
			end
			pdle_pkg::ST_POP_LD: state_d = pdle_pkg::ST_DN_L;
			pdle_pkg::ST_DN_L: begin
				if (lidx < (IB+1)'(count_q)) begin
					raddr = lidx[IB-1:0];
					state_d = pdle_pkg::ST_DN_R;
				end else begin
					we = 1'b1;
					state_d = pdle_pkg::ST_ROOT_RD;
				end
			end
			pdle_pkg::ST_DN_R: begin
				raddr = ridx[IB-1:0];
				state_d = pdle_pkg::ST_DN_CMP;
			end
			pdle_pkg::ST_DN_CMP: begin
				we = 1'b1;
				if ((ridx < (IB+1)'(count_q)) && right_first) begin
					wdata = rdata;
					state_d = pdle_pkg::ST_DN_L;
				end else if (best_idx_q != idx_q) begin
					wdata = best_q;
					state_d = pdle_pkg::ST_DN_L;
				end else begin
					state_d = pdle_pkg::ST_ROOT_RD;
				end
			end
			default: state_d = pdle_pkg::ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pdle_pkg::ST_IDLE;
			count_q <= '0;
			now_q <= '0;
			arr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == pdle_pkg::ST_EXEC) begin
				if (cmd_q.command) now_q <= now_q + 32'd1;
				if (status_kind == pdle_pkg::KIND_QUEUED) begin
					count_q <= count_q + CB'(1);
					arr_q <= arr_q + 16'd1;
				end
			end else if (state_q == pdle_pkg::ST_ROOT_CHK && root_due) begin
				count_q <= count_q - CB'(1);
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			pdle_pkg::ST_IDLE: if (start) cmd_q <= cmd;
			pdle_pkg::ST_CALC: prod_q <= {16'd0, cmd_q.rand_delay} * ({16'd0, span_q} + 32'd1);
			pdle_pkg::ST_EXEC: begin
				pend_kind_q <= status_kind;
				pend_handle_q <= '0;
				cur_q <= new_slot;
				idx_q <= count_q[IB-1:0];
			end
			pdle_pkg::ST_UP_CMP: if (pdle_pkg::goes_first(cur_q, rdata, now_q)) idx_q <= parent;
			pdle_pkg::ST_ROOT_CHK: begin
				if (root_due) begin
					pend_kind_q <= pdle_pkg::KIND_RELEASED;
					pend_handle_q <= 8'(rdata.handle);
				end
			end
			pdle_pkg::ST_POP_LD: begin
				cur_q <= rdata;
				idx_q <= '0;
			end
			pdle_pkg::ST_DN_R: begin
				best_q <= left_first ? rdata : cur_q;
				best_idx_q <= left_first ? lidx[IB-1:0] : idx_q;
			end
			pdle_pkg::ST_DN_CMP: begin
				if ((ridx < (IB+1)'(count_q)) && right_first) idx_q <= ridx[IB-1:0];
				else idx_q <= best_idx_q;
			end
			default: ;
		endcase
	end

endmodule
